[hw/rtl/assert_macros.svh]
// Assertion helpers for the accept-key engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define WSK_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define WSK_ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WSK_ASSERT(label, clk, rst_n, prop, msg)
`define WSK_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

[hw/rtl/wsk_pkg.sv]
package wsk_pkg;

  localparam int unsigned KeyLen    = 24;
  localparam int unsigned HdrLen    = 19;
  localparam int unsigned GuidLen   = 36;
  localparam int unsigned MsgLen    = KeyLen + GuidLen;
  localparam int unsigned NumBlocks = (MsgLen + 8) / 64 + 1;
  localparam int unsigned BufLen    = NumBlocks * 64;
  localparam int unsigned AcceptLen = 28;

  localparam int unsigned KeyCntW = $clog2(KeyLen + 1);
  localparam int unsigned BlkW    = (NumBlocks > 1) ? $clog2(NumBlocks) : 1;

  localparam logic [63:0] MsgBits = 64'(MsgLen * 8);

  localparam logic [159:0] ShaInit =
    160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

  // datapath commands
  typedef struct packed {
    logic key_wr;
    logic hash_init;
    logic blk_load;
    logic round;
    logic blk_add;
    logic out_load;
    logic out_shift;
  } wsk_cmd_t;

  // datapath status
  typedef struct packed {
    logic hdr_hit;
    logic first_hit;
  } wsk_sts_t;

  function automatic logic [7:0] hdr_char(input logic [4:0] idx);
    logic [7:0] c;
    case (idx)
      5'd0:  c = "S";
      5'd1:  c = "e";
      5'd2:  c = "c";
      5'd3:  c = "-";
      5'd4:  c = "W";
      5'd5:  c = "e";
      5'd6:  c = "b";
      5'd7:  c = "S";
      5'd8:  c = "o";
      5'd9:  c = "c";
      5'd10: c = "k";
      5'd11: c = "e";
      5'd12: c = "t";
      5'd13: c = "-";
      5'd14: c = "K";
      5'd15: c = "e";
      5'd16: c = "y";
      5'd17: c = ":";
      5'd18: c = " ";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  localparam logic [8*GuidLen-1:0] GuidText = "258EAFA5-E914-47DA-95CA-C5AB0DC85B11";

  function automatic logic [7:0] guid_char(input int unsigned idx);
    return GuidText[8*(GuidLen-1-idx) +: 8];
  endfunction

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26)      c = 8'("A") + 8'(v);
    else if (v < 6'd52) c = 8'("a") + 8'(v - 6'd26);
    else if (v < 6'd62) c = 8'("0") + 8'(v - 6'd52);
    else if (v == 6'd62) c = 8'("+");
    else                c = 8'("/");
    return c;
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

endpackage

[hw/rtl/websocket_accept_key_engine.sv]
// Accept-key engine: header search, key capture, SHA-1, Base64.
// Header and key bytes: one per cycle, never stalled, no result.
// After the last key byte: for each block a load, the SHA-1 rounds and an add,
// then a conversion step loads the first beat; then 29 beats,
// one per cycle while not stalled, input stalled throughout. Later bytes dropped.
// Reset (rst_ni low, asynchronous) returns to the header search.
`include "assert_macros.svh"
module websocket_accept_key_engine import wsk_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] accept_char_o,
  output logic [4:0] char_index_o,
  output logic       last_o
);

  wsk_cmd_t            cmd;
  wsk_sts_t            sts;
  logic [4:0]          match_cnt;
  logic [KeyCntW-1:0]  key_cnt;
  logic [BlkW-1:0]     blk;
  logic [6:0]          rnd;
  logic                out_acc;
  logic [7:0]          char_w;

  wsk_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .out_stall_i, .sts_i(sts),
    .in_stall_o, .out_valid_o, .cmd_o(cmd), .match_cnt_o(match_cnt),
    .key_cnt_o(key_cnt), .blk_o(blk), .round_o(rnd), .char_index_o, .last_o
  );

  wsk_datapath u_dp (
    .clk_i, .rx_byte_i, .cmd_i(cmd), .match_cnt_i(match_cnt), .key_cnt_i(key_cnt),
    .blk_i(blk), .round_i(rnd), .sts_o(sts), .char_o(char_w)
  );

  assign out_acc       = out_valid_o && !out_stall_i;
  // 20-byte digest: 27 digits, then one '=' of padding
  assign accept_char_o = last_o ? 8'h00 :
                         (char_index_o == 5'(AcceptLen - 1) ? 8'("=") : char_w);

  `WSK_ASSERT(a_out_state, clk_i, rst_ni, out_valid_o |-> in_stall_o, "input open during output")
  `WSK_ASSERT(a_idx_rng, clk_i, rst_ni, out_valid_o |-> char_index_o <= 5'(AcceptLen), "index range")
  `WSK_ASSERT(a_last_done, clk_i, rst_ni, (out_acc && last_o) |=> !out_valid_o, "no stop after last")

endmodule

[hw/rtl/wsk_datapath.sv]
module wsk_datapath import wsk_pkg::*; (
  input  logic           clk_i,
  input  logic [7:0]     rx_byte_i,
  input  wsk_cmd_t       cmd_i,
  input  logic [4:0]     match_cnt_i,
  input  logic [KeyCntW-1:0] key_cnt_i,
  input  logic [BlkW-1:0] blk_i,
  input  logic [6:0]     round_i,
  output wsk_sts_t       sts_o,
  output logic [7:0]     char_o
);

  logic [7:0]   key_q [KeyLen];
  logic [159:0] h_q;
  logic [31:0]  w_q [16];
  logic [31:0]  a_q, b_q, c_q, d_q, e_q;
  logic [167:0] out_q;  // 28 six-bit digits

  assign sts_o.hdr_hit   = (rx_byte_i == hdr_char(match_cnt_i));
  assign sts_o.first_hit = (rx_byte_i == hdr_char(5'd0));
  assign char_o          = b64_char(out_q[167 -: 6]);

  // message byte at a buffer position
  function automatic logic [7:0] msg_byte(input int unsigned p,
                                          input logic [7:0] k [KeyLen]);
    logic [7:0] v;
    if (p < KeyLen)               v = k[p];
    else if (p < MsgLen)          v = guid_char(p - KeyLen);
    else if (p == MsgLen)         v = 8'h80;
    else if (p >= BufLen - 8)     v = MsgBits[8*(BufLen-1-p) +: 8];
    else                          v = 8'h00;
    return v;
  endfunction

  logic [31:0] blk_words [16];
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      blk_words[i] = 32'h0;
      for (int n = 0; n < NumBlocks; n++) begin
        if (blk_i == BlkW'(n)) begin
          blk_words[i] = {msg_byte(n*64+4*i, key_q), msg_byte(n*64+4*i+1, key_q),
                          msg_byte(n*64+4*i+2, key_q), msg_byte(n*64+4*i+3, key_q)};
        end
      end
    end
  end

  logic [31:0] w_new, f, kc, t;
  always_comb begin
    w_new = rotl(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0], 1);
    if (round_i < 7'd20) begin
      f = (b_q & c_q) | (~b_q & d_q);  kc = 32'h5A827999;
    end else if (round_i < 7'd40) begin
      f = b_q ^ c_q ^ d_q;             kc = 32'h6ED9EBA1;
    end else if (round_i < 7'd60) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q); kc = 32'h8F1BBCDC;
    end else begin
      f = b_q ^ c_q ^ d_q;             kc = 32'hCA62C1D6;
    end
    t = rotl(a_q, 5) + f + e_q + kc + w_q[0];
  end

  // digits of the digest, padded with two zero bits
  logic [161:0] dig_pad;
  logic [167:0] digits;
  always_comb begin
    dig_pad = {h_q, 2'b00};
    for (int i = 0; i < 27; i++) digits[167-6*i -: 6] = 6'(dig_pad[161-6*i -: 6]);
    digits[5:0] = 6'd63;  // padding slot, replaced by '=' at the output
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.key_wr) begin
      key_q[key_cnt_i[$clog2(KeyLen)-1:0]] <= rx_byte_i;
    end
    if (cmd_i.hash_init) h_q <= ShaInit;
    if (cmd_i.blk_load) begin
      for (int i = 0; i < 16; i++) w_q[i] <= blk_words[i];
      {a_q, b_q, c_q, d_q, e_q} <= h_q;
    end
    if (cmd_i.round) begin
      // rolling window: w_q[0] is always the current word, w_q[15] takes the word 16 ahead
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= w_new;
      e_q <= d_q;
      d_q <= c_q;
      c_q <= rotl(b_q, 30);
      b_q <= a_q;
      a_q <= t;
    end
    if (cmd_i.blk_add) begin
      h_q <= {h_q[159:128] + a_q, h_q[127:96] + b_q, h_q[95:64] + c_q,
              h_q[63:32] + d_q, h_q[31:0] + e_q};
    end
    if (cmd_i.out_load) out_q <= digits;
    if (cmd_i.out_shift) out_q <= {out_q[161:0], 6'h00};
  end

endmodule

[hw/rtl/wsk_ctrl.sv]
module wsk_ctrl import wsk_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               out_stall_i,
  input  wsk_sts_t           sts_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  output wsk_cmd_t           cmd_o,
  output logic [4:0]         match_cnt_o,
  output logic [KeyCntW-1:0] key_cnt_o,
  output logic [BlkW-1:0]    blk_o,
  output logic [6:0]         round_o,
  output logic [4:0]         char_index_o,
  output logic               last_o
);

  localparam logic [2:0] StHdr = 3'd0, StKey = 3'd1, StLoad = 3'd2, StRound = 3'd3,
                         StAdd = 3'd4, StConv = 3'd5, StOut = 3'd6, StDone = 3'd7;

  logic [2:0]          state_q, state_d;
  logic [4:0]          match_q, match_d;
  logic [KeyCntW-1:0]  kcnt_q, kcnt_d;
  logic [BlkW-1:0]     blk_q, blk_d;
  logic [6:0]          rnd_q, rnd_d;
  logic [4:0]          oidx_q, oidx_d;
  logic                in_acc, out_acc;

  assign in_stall_o   = !(state_q inside {StHdr, StKey, StDone});
  assign in_acc       = in_valid_i && !in_stall_o;
  assign out_valid_o  = (state_q == StOut);
  assign out_acc      = out_valid_o && !out_stall_i;
  assign last_o       = (oidx_q == 5'(AcceptLen));
  assign char_index_o = oidx_q;
  assign match_cnt_o  = match_q;
  assign key_cnt_o    = kcnt_q;
  assign blk_o        = blk_q;
  assign round_o      = rnd_q;

  always_comb begin
    state_d = state_q; match_d = match_q; kcnt_d = kcnt_q; blk_d = blk_q;
    rnd_d = rnd_q; oidx_d = oidx_q; cmd_o = '0;
    case (state_q)
      StHdr: if (in_acc) begin
        match_d = sts_i.hdr_hit ? match_q + 5'd1 : (sts_i.first_hit ? 5'd1 : 5'd0);
        if (sts_i.hdr_hit && match_q == 5'(HdrLen - 1)) begin
          state_d = StKey; kcnt_d = '0; match_d = '0;
        end
      end
      StKey: if (in_acc) begin
        cmd_o.key_wr = 1'b1;
        kcnt_d = kcnt_q + 1'b1;
        if (kcnt_q == KeyCntW'(KeyLen - 1)) begin
          state_d = StLoad; cmd_o.hash_init = 1'b1; blk_d = '0;
        end
      end
      StLoad: begin
        cmd_o.blk_load = 1'b1; rnd_d = '0; state_d = StRound;
      end
      StRound: begin
        cmd_o.round = 1'b1; rnd_d = rnd_q + 7'd1;
        if (rnd_q == 7'd79) state_d = StAdd;
      end
      StAdd: begin
        cmd_o.blk_add = 1'b1;
        if (blk_q == BlkW'(NumBlocks - 1)) state_d = StConv;
        else begin
          blk_d = blk_q + 1'b1; state_d = StLoad;
        end
      end
      StConv: begin
        cmd_o.out_load = 1'b1; oidx_d = '0; state_d = StOut;
      end
      StOut: if (out_acc) begin
        cmd_o.out_shift = 1'b1; oidx_d = oidx_q + 5'd1;
        if (last_o) state_d = StDone;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StHdr; match_q <= '0; kcnt_q <= '0; blk_q <= '0;
      rnd_q <= '0; oidx_q <= '0;
    end else begin
      state_q <= state_d; match_q <= match_d; kcnt_q <= kcnt_d; blk_q <= blk_d;
      rnd_q <= rnd_d; oidx_q <= oidx_d;
    end
  end

endmodule

[sim/accept_key_checker.sv]
`timescale 1ns / 100ps
module accept_key_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] rx_byte_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] accept_char_i,
  input  logic [4:0] char_index_i,
  input  logic       last_i,
  output int         errors_o,
  output int         pending_o,
  output int         beats_o
);
  import wsk_pkg::*;

  typedef struct {
    logic [7:0] ch;
    logic [4:0] idx;
    logic       last;
  } accept_beat_t;

  typedef enum logic [1:0] {
    SEARCH  = 2'd0,
    COLLECT = 2'd1,
    DONE    = 2'd2
  } scan_phase_e;

  localparam string HdrText = "Sec-WebSocket-Key: ";
  localparam string Guid    = "258EAFA5-E914-47DA-95CA-C5AB0DC85B11";
  localparam string Alpha   =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  accept_beat_t accept_q[$];
  scan_phase_e  scan_phase;
  int           hdr_hits;
  int           key_seen;
  logic [7:0]   key_bytes[KeyLen];

  task automatic report(input string what, input int got, input int want);
    $display("%0t: %s got %0h want %0h", $realtime, what, got, want);
    errors_o++;
  endtask

  // SHA-1 over key+GUID, then Base64 of the digest
  function automatic void accept_string(output logic [7:0] chars[AcceptLen]);
    logic [7:0]  msg[128];
    logic [31:0] h[5];
    logic [31:0] w[80];
    logic [31:0] a, b, c, d, e, f, k, t, x;
    logic [7:0]  dig[20];
    logic [23:0] g;
    h[0] = 32'h67452301; h[1] = 32'hEFCDAB89; h[2] = 32'h98BADCFE;
    h[3] = 32'h10325476; h[4] = 32'hC3D2E1F0;
    for (int i = 0; i < 128; i++) msg[i] = 8'h00;
    for (int i = 0; i < KeyLen; i++) msg[i] = key_bytes[i];
    for (int i = 0; i < 36; i++) msg[KeyLen + i] = Guid[i];
    msg[KeyLen + 36] = 8'h80;
    msg[126] = 8'((KeyLen + 36) * 8 >> 8);
    msg[127] = 8'((KeyLen + 36) * 8);
    for (int blk = 0; blk < 2; blk++) begin
      for (int j = 0; j < 16; j++)
        w[j] = {msg[64*blk+4*j], msg[64*blk+4*j+1], msg[64*blk+4*j+2], msg[64*blk+4*j+3]};
      for (int j = 16; j < 80; j++) begin
        x = w[j-3] ^ w[j-8] ^ w[j-14] ^ w[j-16];
        w[j] = {x[30:0], x[31]};
      end
      a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4];
      for (int j = 0; j < 80; j++) begin
        if (j < 20) begin
          f = (b & c) | (~b & d); k = 32'h5A827999;
        end else if (j < 40) begin
          f = b ^ c ^ d; k = 32'h6ED9EBA1;
        end else if (j < 60) begin
          f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
        end else begin
          f = b ^ c ^ d; k = 32'hCA62C1D6;
        end
        t = {a[26:0], a[31:27]} + f + e + k + w[j];
        e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = t;
      end
      h[0] += a; h[1] += b; h[2] += c; h[3] += d; h[4] += e;
    end
    for (int i = 0; i < 20; i++) dig[i] = h[i/4][31 - 8*(i%4) -: 8];
    for (int i = 0; i < 7; i++) begin
      g = {dig[3*i], (3*i+1 < 20) ? dig[3*i+1] : 8'h00, (3*i+2 < 20) ? dig[3*i+2] : 8'h00};
      chars[4*i]   = Alpha[g[23:18]];
      chars[4*i+1] = Alpha[g[17:12]];
      chars[4*i+2] = (3*i+1 < 20) ? Alpha[g[11:6]] : "=";
      chars[4*i+3] = (3*i+2 < 20) ? Alpha[g[5:0]] : "=";
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [7:0]   chars[AcceptLen];
    accept_beat_t want;
    if (!rst_ni) begin
      scan_phase = SEARCH;
      hdr_hits   = 0;
      key_seen   = 0;
      accept_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        beats_o++;
        if (accept_q.size() == 0) begin
          report("unexpected beat, char", accept_char_i, 0);
        end else begin
          want = accept_q.pop_front();
          if (accept_char_i !== want.ch) report("accept_char", accept_char_i, want.ch);
          if (char_index_i !== want.idx) report("char_index", char_index_i, want.idx);
          if (last_i !== want.last) report("last", last_i, want.last);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        case (scan_phase)
          SEARCH: begin
            if (hdr_hits < HdrLen && rx_byte_i == HdrText[hdr_hits]) hdr_hits++;
            else hdr_hits = (rx_byte_i == HdrText[0]) ? 1 : 0;
            if (hdr_hits >= HdrLen) begin
              scan_phase = COLLECT;
              hdr_hits   = 0;
              key_seen   = 0;
            end
          end
          COLLECT: begin
            key_bytes[key_seen] = rx_byte_i;
            key_seen++;
            if (key_seen >= KeyLen) begin
              scan_phase = DONE;
              accept_string(chars);
              for (int i = 0; i < AcceptLen; i++)
                accept_q.push_back('{chars[i], 5'(i), 1'b0});
              accept_q.push_back('{8'h00, 5'(AcceptLen), 1'b1});
            end
          end
          default: ;
        endcase
      end
    end
    pending_o = accept_q.size();
  end

  initial begin
    errors_o  = 0;
    pending_o = 0;
    beats_o   = 0;
  end
endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
module tb;
  import wsk_pkg::*;

  localparam int    IdleLimit = 20000;
  localparam string HdrText   = "Sec-WebSocket-Key: ";

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] rx_byte = 8'h00;
  logic       out_stall = 1'b0;
  logic       in_stall, out_valid, last;
  logic [7:0] accept_char;
  logic [4:0] char_index;
  int         errors, pending, beats;
  int         idle_cycles = 0;
  int         stall_mode = 0;
  int         sent = 0;
  logic [7:0] stream_q[$];
  int         pause_at;

  always #2 clk = ~clk;

  websocket_accept_key_engine i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .rx_byte_i(rx_byte),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .accept_char_o(accept_char), .char_index_o(char_index), .last_o(last)
  );

  accept_key_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .rx_byte_i(rx_byte),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .accept_char_i(accept_char), .char_index_i(char_index), .last_i(last),
    .errors_o(errors), .pending_o(pending), .beats_o(beats)
  );

  // receiver back-pressure: the stall mode changes at random among four modes
  always @(posedge clk) begin
    if (($urandom & 63) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= $urandom_range(0, 1);
      2: out_stall <= ($urandom_range(0, 9) < 8);
      default: out_stall <= ~out_stall;
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("websocket_accept_key_engine: mismatch");
      $finish;
    end
  end

  task automatic push_text(input string s, input int n);
    for (int i = 0; i < n; i++) stream_q.push_back(s[i]);
  endtask

  initial begin
    int len, burst;
    // directed: extremes, restart on mismatch, restart on repeated 'S'
    stream_q = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h55, 8'hAA};
    push_text("Sec-Wx", 6);
    push_text("SSec-", 5);
    push_text("Sec-WebSocket-Key:", 18);
    stream_q.push_back("S");
    // random: noise and broken header prefixes
    while (stream_q.size() < 360) begin
      if ($urandom_range(0, 2) == 0) begin
        stream_q.push_back(8'($urandom));
      end else begin
        len = $urandom_range(1, HdrLen - 1);
        push_text(HdrText, len);
        stream_q.push_back($urandom_range(0, 1) ? "S" : 8'($urandom));
      end
    end
    push_text(HdrText, HdrLen);
    for (int i = 0; i < KeyLen; i++) stream_q.push_back(8'($urandom));
    pause_at = stream_q.size();
    // bytes after completion are dropped
    push_text(HdrText, HdrLen);
    for (int i = 0; i < 20; i++) stream_q.push_back(8'($urandom));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    burst = 0;
    while (sent < stream_q.size()) begin
      if (sent == pause_at) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end else if (burst == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(0, 1) ? 0 : $urandom_range(1, 12)) @(posedge clk);
        burst = $urandom_range(1, 40);
      end
      in_valid <= 1'b1;
      rx_byte  <= stream_q[sent];
      do @(posedge clk); while (in_stall);
      sent++;
      burst--;
    end
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (2 * NumBlocks * 82 + 50) @(posedge clk);
    $display("sent %0d bytes (noise, broken and full header, key, trailing)", sent);
    $display("received %0d accept beats, %0d errors", beats, errors);
    if (errors == 0) $display("websocket_accept_key_engine: match");
    else $display("websocket_accept_key_engine: mismatch");
    $finish;
  end
endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/wsk_pkg.sv
hw/rtl/wsk_datapath.sv
hw/rtl/wsk_ctrl.sv
hw/rtl/websocket_accept_key_engine.sv
sim/accept_key_checker.sv
sim/tb.sv
